>>> rtl/lcdns_pkg.sv
package lcdns_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int BEFORE_W  = 16;
  localparam int AFTER_W   = 13;
  localparam int STEP_W    = 4;

  // Command opcodes
  localparam logic [1:0] OP_STARTUP = 2'd0;
  localparam logic [1:0] OP_INSTR   = 2'd1;
  localparam logic [1:0] OP_CHAR    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_CMD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_SET_CMD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_OFF_CMD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CMD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CMD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_ON_CMD  = 3'd5;

  localparam logic [BYTE_W-1:0] RST_RESET_CMD    = 8'h30;
  localparam logic [BYTE_W-1:0] RST_FUNC_SET_CMD = 8'h28;
  localparam logic [BYTE_W-1:0] RST_DISP_OFF_CMD = 8'h08;
  localparam logic [BYTE_W-1:0] RST_CLEAR_CMD    = 8'h01;
  localparam logic [BYTE_W-1:0] RST_ENTRY_CMD    = 8'h06;
  localparam logic [BYTE_W-1:0] RST_DISP_ON_CMD  = 8'h0C;

  localparam logic [BEFORE_W-1:0] WAIT_POWER_US  = 16'd50000;
  localparam logic [AFTER_W-1:0]  WAIT_RESET1_US = 13'd5000;
  localparam logic [AFTER_W-1:0]  WAIT_RESET_US  = 13'd125;
  localparam logic [AFTER_W-1:0]  WAIT_CMD_US    = 13'd50;
  localparam logic [AFTER_W-1:0]  WAIT_CLEAR_US  = 13'd2000;

  localparam logic [STEP_W-1:0] STARTUP_LAST = 4'd13;
  localparam logic [STEP_W-1:0] BYTE_LAST    = 4'd1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                reg_select;
    logic [NIB_W-1:0]    nibble;
    logic [BEFORE_W-1:0] wait_before_us;
    logic [AFTER_W-1:0]  wait_after_us;
    logic                last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_STARTUP,
    KIND_INSTR,
    KIND_CHAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data_byte;
  } cmd_desc_t;

  typedef struct packed {
    logic [BYTE_W-1:0] reset_cmd;
    logic [BYTE_W-1:0] func_set_cmd;
    logic [BYTE_W-1:0] disp_off_cmd;
    logic [BYTE_W-1:0] clear_cmd;
    logic [BYTE_W-1:0] entry_cmd;
    logic [BYTE_W-1:0] disp_on_cmd;
  } cfg_regs_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage

>>> rtl/lcdns_front.sv
module lcdns_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdns_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                               in_push,
  output logic                               in_full,
  input  lcdns_pkg::in_item_t                in_item,
  output logic                               q_push,
  output lcdns_pkg::cmd_desc_t               q_desc,
  input  logic                               q_full,
  output lcdns_pkg::cfg_regs_t               cfg_regs
);

  lcdns_pkg::cfg_regs_t cfg_r;
  logic                 accept;
  logic                 known_op;

  assign cfg_ready = 1'b1;
  assign cfg_regs  = cfg_r;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_cmd    <= lcdns_pkg::RST_RESET_CMD;
      cfg_r.func_set_cmd <= lcdns_pkg::RST_FUNC_SET_CMD;
      cfg_r.disp_off_cmd <= lcdns_pkg::RST_DISP_OFF_CMD;
      cfg_r.clear_cmd    <= lcdns_pkg::RST_CLEAR_CMD;
      cfg_r.entry_cmd    <= lcdns_pkg::RST_ENTRY_CMD;
      cfg_r.disp_on_cmd  <= lcdns_pkg::RST_DISP_ON_CMD;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcdns_pkg::CFG_RESET_CMD:    cfg_r.reset_cmd    <= cfg_data;
        lcdns_pkg::CFG_FUNC_SET_CMD: cfg_r.func_set_cmd <= cfg_data;
        lcdns_pkg::CFG_DISP_OFF_CMD: cfg_r.disp_off_cmd <= cfg_data;
        lcdns_pkg::CFG_CLEAR_CMD:    cfg_r.clear_cmd    <= cfg_data;
        lcdns_pkg::CFG_ENTRY_CMD:    cfg_r.entry_cmd    <= cfg_data;
        lcdns_pkg::CFG_DISP_ON_CMD:  cfg_r.disp_on_cmd  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the opcode; drop the unused code
  always_comb begin
    known_op         = 1'b1;
    q_desc.kind      = lcdns_pkg::KIND_STARTUP;
    q_desc.data_byte = in_item.data_byte;
    case (in_item.opcode)
      lcdns_pkg::OP_STARTUP: q_desc.kind = lcdns_pkg::KIND_STARTUP;
      lcdns_pkg::OP_INSTR:   q_desc.kind = lcdns_pkg::KIND_INSTR;
      lcdns_pkg::OP_CHAR:    q_desc.kind = lcdns_pkg::KIND_CHAR;
      default:               known_op    = 1'b0;
    endcase
  end

  assign q_push = accept && known_op;

endmodule

>>> rtl/lcdns_cmd_fifo.sv
module lcdns_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcdns_pkg::cmd_desc_t wr_data,
  output logic                 full,
  input  logic                 pop,
  output lcdns_pkg::cmd_desc_t rd_data,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  lcdns_pkg::cmd_desc_t mem_r [DEPTH];
  logic [AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]        count_r;
  logic                 do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/lcdns_back.sv
module lcdns_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdns_pkg::cfg_regs_t cfg_regs,
  input  lcdns_pkg::cmd_desc_t q_desc,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output lcdns_pkg::out_item_t out_item
);

  lcdns_pkg::back_state_t          state_r, state_nxt;
  logic [lcdns_pkg::STEP_W-1:0]    step_r, step_nxt;
  lcdns_pkg::cmd_desc_t            desc_r;
  logic                            out_valid_r, out_valid_nxt;
  lcdns_pkg::out_item_t            out_item_r;
  lcdns_pkg::out_item_t            strobe;
  logic                            adv;
  logic [lcdns_pkg::BYTE_W-1:0]    sel_byte;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // Strobe for the current step
  always_comb begin
    strobe.reg_select     = 1'b0;
    strobe.nibble         = '0;
    strobe.wait_before_us = '0;
    strobe.wait_after_us  = '0;
    strobe.last           = 1'b0;
    sel_byte              = desc_r.data_byte;
    case (desc_r.kind)
      lcdns_pkg::KIND_STARTUP: begin
        case (step_r[3:1])
          3'd2:    sel_byte = cfg_regs.func_set_cmd;
          3'd3:    sel_byte = cfg_regs.disp_off_cmd;
          3'd4:    sel_byte = cfg_regs.clear_cmd;
          3'd5:    sel_byte = cfg_regs.entry_cmd;
          default: sel_byte = cfg_regs.disp_on_cmd;
        endcase
        case (step_r)
          4'd0: begin
            strobe.nibble         = cfg_regs.reset_cmd[7:4];
            strobe.wait_before_us = lcdns_pkg::WAIT_POWER_US;
            strobe.wait_after_us  = lcdns_pkg::WAIT_RESET1_US;
          end
          4'd1, 4'd2: begin
            strobe.nibble        = cfg_regs.reset_cmd[7:4];
            strobe.wait_after_us = lcdns_pkg::WAIT_RESET_US;
          end
          4'd3: begin
            strobe.nibble        = cfg_regs.func_set_cmd[7:4];
            strobe.wait_after_us = lcdns_pkg::WAIT_CMD_US;
          end
          default: begin
            if (step_r[0]) begin
              strobe.nibble        = sel_byte[3:0];
              strobe.wait_after_us = (step_r[3:1] == 3'd4) ? lcdns_pkg::WAIT_CLEAR_US
                                                            : lcdns_pkg::WAIT_CMD_US;
            end else begin
              strobe.nibble = sel_byte[7:4];
            end
          end
        endcase
        strobe.last = (step_r == lcdns_pkg::STARTUP_LAST);
      end
      default: begin
        strobe.reg_select = (desc_r.kind == lcdns_pkg::KIND_CHAR);
        if (step_r[0]) begin
          strobe.nibble = desc_r.data_byte[3:0];
          if (desc_r.kind == lcdns_pkg::KIND_CHAR) begin
            strobe.wait_after_us = lcdns_pkg::WAIT_CMD_US;
          end
        end else begin
          strobe.nibble = desc_r.data_byte[7:4];
        end
        strobe.last = (step_r == lcdns_pkg::BYTE_LAST);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    q_pop         = 1'b0;
    adv           = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    case (state_r)
      lcdns_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          step_nxt  = '0;
          state_nxt = lcdns_pkg::B_RUN;
        end
      end
      lcdns_pkg::B_RUN: begin
        if (!out_valid_r || out_pop) begin
          adv           = 1'b1;
          out_valid_nxt = 1'b1;
          step_nxt      = step_r + lcdns_pkg::STEP_W'(1);
          if (strobe.last) begin
            state_nxt = lcdns_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = lcdns_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcdns_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_desc;
    end
    if (adv) begin
      out_item_r <= strobe;
    end
  end

endmodule

>>> rtl/char_lcd_nibble_sequencer_top.sv
// A command passes the queue and the sequencer's descriptor register, loaded when the
//   previous run ends. Start-up is a run of 14 strobes, a byte command one per nibble; the
//   step counter emits one strobe per cycle while the result register is empty or popped.
// The front side keeps taking commands into a CMD_QUEUE_DEPTH-entry queue meanwhile.
// Reset: synchronous, active low; clears queue, sequencer and result valid flag and
//   restores the configuration registers to their power-on command bytes.
module char_lcd_nibble_sequencer_top #(
  parameter int CMD_QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdns_pkg::BYTE_W-1:0]       cfg_data,
  // command input, queue style
  input  logic                               in_push,
  output logic                               in_full,
  input  lcdns_pkg::in_item_t                in_item,
  // strobe output, queue style
  output logic                               out_empty,
  input  logic                               out_pop,
  output lcdns_pkg::out_item_t               out_item
);

  // Front to queue
  logic                 q_push, q_full;
  lcdns_pkg::cmd_desc_t q_wr_desc;
  // Queue to back
  logic                 q_pop, q_empty;
  lcdns_pkg::cmd_desc_t q_rd_desc;
  lcdns_pkg::cfg_regs_t cfg_regs;

  // Hold the configuration, classify each command transfer and drop the unused opcode.
  lcdns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_push    (q_push),
    .q_desc    (q_wr_desc),
    .q_full    (q_full),
    .cfg_regs  (cfg_regs)
  );

  // Decouple the two sides so each can stall on its own.
  lcdns_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_desc),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_desc),
    .empty   (q_empty)
  );

  // Walk each command's strobe run into the result register; advance when it is empty or popped.
  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .q_desc    (q_rd_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
